// ----- rtl/shans_pkg.sv -----
// shared types and constants for the sha256 nonce search
`timescale 1ns / 1ps
package shans_pkg;

  localparam int NUM_KEY_REGS = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int DIFF_W       = 9;
  localparam logic [DIFF_W-1:0] MAX_DIFFICULTY = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFICULTY = 3'd4;

  localparam logic [31:0] PAD_WORD = 32'h8000_0000;
  localparam logic [31:0] LEN_WORD = 32'd320;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef logic [31:0] word_t;

  // control from sequencer to round core
  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] round;
  } core_ctl_t;

  function automatic word_t swap32(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ----- rtl/shans_if.sv -----
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface shans_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] challenge;
  modport source (output valid, challenge, input ready);
  modport sink (input valid, challenge, output ready);
endinterface

interface shans_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] nonce;
  logic [63:0] digest_word0;
  logic [63:0] digest_word1;
  logic [63:0] digest_word2;
  logic [63:0] digest_word3;
  modport source (output valid, status, nonce, digest_word0, digest_word1,
                  digest_word2, digest_word3, input ready);
  modport sink (input valid, status, nonce, digest_word0, digest_word1,
                digest_word2, digest_word3, output ready);
endinterface

interface shans_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/shans_core.sv -----
// sha256 round unit with message schedule, one round per cycle while step is set
`timescale 1ns / 1ps
module shans_core (
  input  logic                  clk,
  input  shans_pkg::core_ctl_t  ctl,
  input  shans_pkg::word_t      blk [16],
  output shans_pkg::word_t      dig [8]
);

  shans_pkg::word_t v_r [8];
  shans_pkg::word_t v_nxt [8];
  shans_pkg::word_t w_r [16];
  shans_pkg::word_t w_nxt [16];
  shans_pkg::word_t wi, t1, t2, s0, s1, ws0, ws1, a, e;

  always_comb begin
    a   = v_r[0];
    e   = v_r[4];
    ws0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    ws1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
          ^ (w_r[14] >> 10);
    wi  = (ctl.round < 6'd16) ? w_r[0] : (w_r[0] + ws0 + w_r[9] + ws1);
    s1  = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    t1  = v_r[7] + s1 + ((e & v_r[5]) ^ (~e & v_r[6])) + shans_pkg::ROUND_K[ctl.round] + wi;
    s0  = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    t2  = s0 + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
    v_nxt = v_r;
    w_nxt = w_r;
    if (ctl.load) begin
      v_nxt = shans_pkg::INIT_H;
      w_nxt = blk;
    end else if (ctl.step) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
      // window shifts each step; slot 0 holds the current word in rounds 0 to 15, word t-16 after
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
      w_nxt[15] = wi;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) dig[i] = shans_pkg::INIT_H[i] + v_r[i];
  end

endmodule

// ----- rtl/sha256_nonce_search.sv -----
// top level of the sha256 nonce search
`timescale 1ns / 1ps
// Takes a 32-bit challenge and searches nonces from 0 upward for a single-block
// sha256 of key, challenge and nonce whose leading difficulty bits are zero.
// Each attempt is one load step, 64 rounds through the shared round unit and
// one check step. The block is not ready for input while a search or its
// result is pending. Status 1 with zero fields means all 2^32 nonces failed.
module sha256_nonce_search (
  input logic          clk,
  input logic          rst_n,
  shans_in_if.sink     in_ch,
  shans_out_if.source  out_ch,
  shans_cfg_if.sink    cfg_ch
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_CHECK = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t               state_r, state_nxt;
  logic [63:0]          key_r [shans_pkg::NUM_KEY_REGS];
  logic [shans_pkg::DIFF_W-1:0] diff_r;
  logic [31:0]          chal_r, nonce_r, nonce_nxt;
  logic [5:0]           round_r, round_nxt;
  logic                 status_r;
  shans_pkg::word_t     dres_r [8];
  shans_pkg::word_t     blk [16];
  shans_pkg::word_t     dig [8];
  shans_pkg::core_ctl_t ctl;
  logic [255:0]         dflat, mask;
  logic                 ok;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.status = status_r;
  assign out_ch.nonce  = status_r ? 32'd0 : nonce_r;
  assign out_ch.digest_word0 = status_r ? 64'd0 : {dres_r[0], dres_r[1]};
  assign out_ch.digest_word1 = status_r ? 64'd0 : {dres_r[2], dres_r[3]};
  assign out_ch.digest_word2 = status_r ? 64'd0 : {dres_r[4], dres_r[5]};
  assign out_ch.digest_word3 = status_r ? 64'd0 : {dres_r[6], dres_r[7]};

  always_comb begin
    for (int i = 0; i < shans_pkg::NUM_KEY_REGS; i++) begin
      blk[2*i]   = key_r[i][63:32];
      blk[2*i+1] = key_r[i][31:0];
    end
    blk[8]  = shans_pkg::swap32(chal_r);
    blk[9]  = shans_pkg::swap32(nonce_r);
    blk[10] = shans_pkg::PAD_WORD;
    blk[11] = '0;
    blk[12] = '0;
    blk[13] = '0;
    blk[14] = '0;
    blk[15] = shans_pkg::LEN_WORD;
  end

  assign ctl.load  = (state_r == ST_LOAD);
  assign ctl.step  = (state_r == ST_ROUND);
  assign ctl.round = round_r;

  shans_core u_core (.clk(clk), .ctl(ctl), .blk(blk), .dig(dig));

  // leading-bits mask, msb first
  always_comb begin
    dflat = {dig[0], dig[1], dig[2], dig[3], dig[4], dig[5], dig[6], dig[7]};
    mask  = (diff_r == 9'd0) ? 256'd0 : ~(256'd0) << (9'd256 - diff_r);
    ok    = ((dflat & mask) == 256'd0);
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    nonce_nxt = nonce_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_LOAD;
          nonce_nxt = '0;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_ROUND;
        round_nxt = '0;
      end
      ST_ROUND: begin
        round_nxt = round_r + 6'd1;
        if (round_r == 6'd63) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (ok || nonce_r == 32'hFFFF_FFFF) state_nxt = ST_OUT;
        else begin
          nonce_nxt = nonce_r + 32'd1;
          state_nxt = ST_LOAD;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      round_r <= '0;
      nonce_r <= '0;
      diff_r  <= '0;
      for (int i = 0; i < shans_pkg::NUM_KEY_REGS; i++) key_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
      nonce_r <= nonce_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          shans_pkg::REG_KEY0: key_r[0] <= cfg_ch.data;
          shans_pkg::REG_KEY1: key_r[1] <= cfg_ch.data;
          shans_pkg::REG_KEY2: key_r[2] <= cfg_ch.data;
          shans_pkg::REG_KEY3: key_r[3] <= cfg_ch.data;
          shans_pkg::REG_DIFFICULTY:
            diff_r <= (cfg_ch.data[8:0] > shans_pkg::MAX_DIFFICULTY)
                      ? shans_pkg::MAX_DIFFICULTY : cfg_ch.data[8:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_ch.valid) chal_r <= in_ch.challenge;
    if (state_r == ST_CHECK) begin
      status_r <= !ok;
      dres_r   <= dig;
    end
  end

endmodule
